>>> src/ple_pkg.sv
// Package for the positional list engine: sizes, function and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package ple_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int STAT_W   = 3;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 8;
  localparam int FOUND_W  = 7;
  // widths used to compare and mask without losing bits at any capacity
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int FIX_W    = (IDX_W > FOUND_W) ? IDX_W : FOUND_W;
  localparam int COUT_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_INS_AT    = 3'd2,
    FN_REM_FRONT = 3'd3,
    FN_REM_BACK  = 3'd4,
    FN_REM_AT    = 3'd5,
    FN_SEARCH    = 3'd6
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS,
    OP_REM,
    OP_SRCH
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_UP,
    S_DOWN,
    S_DRAIN,
    S_WRITE,
    S_SCAN,
    S_SCAN_LAST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic rd;
    logic shift;
    logic scan;
    logic wr_val;
    logic cnt_inc;
    logic cnt_dec;
    logic publish;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic early;
    logic direct;
    logic last;
    logic match;
  } sts_t;

endpackage

>>> src/ple_req_if.sv
// Request channel of the positional list engine: valid/ready plus request fields.
// Depends on ple_pkg for field widths.
interface ple_req_if;
  logic                              valid;
  logic                              ready;
  logic [ple_pkg::FUNC_W-1:0]        func;
  logic signed [ple_pkg::WORD_W-1:0] value;
  logic [ple_pkg::POS_W-1:0]         position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

>>> src/ple_rsp_if.sv
// Result channel of the positional list engine: valid/ready plus result fields.
// Depends on ple_pkg for field widths.
interface ple_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ple_pkg::STAT_W-1:0]        status;
  logic signed [ple_pkg::WORD_W-1:0] data_out;
  logic [ple_pkg::FOUND_W-1:0]       found_index;
  logic [ple_pkg::COUNT_W-1:0]       count;

  modport source (output valid, status, data_out, found_index, count, input ready);
  modport sink   (input valid, status, data_out, found_index, count, output ready);
endinterface

>>> src/ple_dp.sv
// Datapath of the positional list engine: entry memory, fill count, shift/scan
// pointers, working result and output payload registers. Depends on ple_pkg.
module ple_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ple_pkg::cmd_t                     cmd,
  output ple_pkg::sts_t                     sts,
  input  logic [ple_pkg::FUNC_W-1:0]        req_func,
  input  logic signed [ple_pkg::WORD_W-1:0] req_value,
  input  logic [ple_pkg::POS_W-1:0]         req_pos,
  output logic [ple_pkg::STAT_W-1:0]        rsp_status,
  output logic signed [ple_pkg::WORD_W-1:0] rsp_data,
  output logic [ple_pkg::FOUND_W-1:0]       rsp_found,
  output logic [ple_pkg::COUNT_W-1:0]       rsp_count
);

  logic signed [ple_pkg::WORD_W-1:0] mem [ple_pkg::CAPACITY];

  ple_pkg::func_t                    func_r;
  logic signed [ple_pkg::WORD_W-1:0] value_r;
  logic [ple_pkg::POS_W-1:0]         pos_r;
  logic [ple_pkg::CNT_W-1:0]         fill_r;
  ple_pkg::op_t                      op_r;
  logic [ple_pkg::IDX_W-1:0]         tgt_r;
  logic [ple_pkg::IDX_W-1:0]         ptr_r;
  logic [ple_pkg::IDX_W-1:0]         end_r;
  logic                              rq_r;
  logic [ple_pkg::IDX_W-1:0]         rq_addr_r;
  logic signed [ple_pkg::WORD_W-1:0] rdata_r;
  ple_pkg::status_t                  res_status_r;
  logic signed [ple_pkg::WORD_W-1:0] res_data_r;
  logic [ple_pkg::IDX_W-1:0]         res_found_r;
  logic [ple_pkg::STAT_W-1:0]        out_status_r;
  logic signed [ple_pkg::WORD_W-1:0] out_data_r;
  logic [ple_pkg::FOUND_W-1:0]       out_found_r;
  logic [ple_pkg::COUNT_W-1:0]       out_count_r;

  logic [ple_pkg::CMP_W-1:0]         pos_x;
  logic [ple_pkg::CMP_W-1:0]         fill_x;
  logic [ple_pkg::CMP_W-1:0]         tgt_x;
  logic [ple_pkg::CNT_W-1:0]         fill_m1;
  logic [ple_pkg::FIX_W-1:0]         found_x;
  logic [ple_pkg::COUT_W-1:0]        count_x;
  ple_pkg::status_t                  chk_st;
  ple_pkg::op_t                      op;
  logic                              match;
  logic                              we;
  logic [ple_pkg::IDX_W-1:0]         waddr;
  logic signed [ple_pkg::WORD_W-1:0] wdata;

  assign fill_m1 = fill_r - ple_pkg::CNT_W'(1);
  assign match   = rq_r && (rdata_r == value_r);
  assign found_x = ple_pkg::FIX_W'(res_found_r);
  assign count_x = ple_pkg::COUT_W'(fill_r);

  // classify the request and check it against the fill count
  always_comb begin
    pos_x  = ple_pkg::CMP_W'(pos_r);
    fill_x = ple_pkg::CMP_W'(fill_r);
    op     = ple_pkg::OP_NONE;
    chk_st = ple_pkg::ST_OK;
    tgt_x  = '0;
    case (func_r)
      ple_pkg::FN_INS_FRONT: begin
        op = ple_pkg::OP_INS;
      end
      ple_pkg::FN_INS_BACK: begin
        op    = ple_pkg::OP_INS;
        tgt_x = fill_x;
      end
      ple_pkg::FN_INS_AT: begin
        op    = ple_pkg::OP_INS;
        tgt_x = pos_x;
        if (pos_x > fill_x) chk_st = ple_pkg::ST_BADIDX;
      end
      ple_pkg::FN_REM_FRONT: begin
        op = ple_pkg::OP_REM;
      end
      ple_pkg::FN_REM_BACK: begin
        op    = ple_pkg::OP_REM;
        tgt_x = fill_x - ple_pkg::CMP_W'(1);
      end
      ple_pkg::FN_REM_AT: begin
        op    = ple_pkg::OP_REM;
        tgt_x = pos_x;
        if (pos_x >= fill_x) chk_st = ple_pkg::ST_BADIDX;
      end
      ple_pkg::FN_SEARCH: begin
        op = ple_pkg::OP_SRCH;
        if (fill_r == '0) chk_st = ple_pkg::ST_NOTFOUND;
      end
      default: begin
        op = ple_pkg::OP_NONE;
      end
    endcase
    // full and empty take precedence over a bad index
    if ((op == ple_pkg::OP_INS) && (fill_r >= ple_pkg::CNT_W'(ple_pkg::CAPACITY)))
      chk_st = ple_pkg::ST_FULL;
    if ((op == ple_pkg::OP_REM) && (fill_r == '0))
      chk_st = ple_pkg::ST_EMPTY;
  end

  always_comb begin
    sts.op     = op;
    sts.early  = (op == ple_pkg::OP_NONE) || (chk_st != ple_pkg::ST_OK);
    sts.direct = (tgt_x == fill_x);
    sts.last   = (ptr_r == end_r);
    sts.match  = match;
  end

  // single write port: either the new word or the word held in the read data register
  always_comb begin
    we    = 1'b0;
    waddr = tgt_r;
    wdata = rdata_r;
    if (cmd.wr_val) begin
      we    = 1'b1;
      wdata = value_r;
    end else if (cmd.shift && rq_r) begin
      if (op_r == ple_pkg::OP_INS) begin
        we    = 1'b1;
        waddr = rq_addr_r + ple_pkg::IDX_W'(1);
      end else if (rq_addr_r != tgt_r) begin
        we    = 1'b1;
        waddr = rq_addr_r - ple_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rdata_r <= mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      rq_r   <= 1'b0;
    end else begin
      rq_r <= cmd.rd;
      if (cmd.cnt_inc) fill_r <= fill_r + ple_pkg::CNT_W'(1);
      else if (cmd.cnt_dec) fill_r <= fill_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= ple_pkg::func_t'(req_func);
      value_r <= req_value;
      pos_r   <= req_pos;
    end
    if (cmd.setup) begin
      op_r         <= op;
      tgt_r        <= tgt_x[ple_pkg::IDX_W-1:0];
      res_status_r <= (op == ple_pkg::OP_SRCH) ? ple_pkg::ST_NOTFOUND : chk_st;
      res_data_r   <= '0;
      res_found_r  <= '0;
      case (op)
        ple_pkg::OP_INS: begin
          ptr_r <= fill_m1[ple_pkg::IDX_W-1:0];
          end_r <= tgt_x[ple_pkg::IDX_W-1:0];
        end
        ple_pkg::OP_REM: begin
          ptr_r <= tgt_x[ple_pkg::IDX_W-1:0];
          end_r <= fill_m1[ple_pkg::IDX_W-1:0];
        end
        default: begin
          ptr_r <= '0;
          end_r <= fill_m1[ple_pkg::IDX_W-1:0];
        end
      endcase
    end
    if (cmd.rd) begin
      rq_addr_r <= ptr_r;
      // insert walks down from the top, remove and search walk up
      if (op_r == ple_pkg::OP_INS) ptr_r <= ptr_r - ple_pkg::IDX_W'(1);
      else ptr_r <= ptr_r + ple_pkg::IDX_W'(1);
    end
    // the first word read by a removal is the one taken out
    if (cmd.shift && rq_r && (op_r == ple_pkg::OP_REM) && (rq_addr_r == tgt_r))
      res_data_r <= rdata_r;
    if (cmd.scan && match) begin
      res_status_r <= ple_pkg::ST_OK;
      res_found_r  <= rq_addr_r;
    end
    if (cmd.publish) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_found_r  <= found_x[ple_pkg::FOUND_W-1:0];
      out_count_r  <= count_x[ple_pkg::COUNT_W-1:0];
    end
  end

  assign rsp_status = out_status_r;
  assign rsp_data   = out_data_r;
  assign rsp_found  = out_found_r;
  assign rsp_count  = out_count_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= ple_pkg::CNT_W'(ple_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> (fill_r < ple_pkg::CNT_W'(ple_pkg::CAPACITY)))
    else $error("insert committed on a full list");

  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_val |-> !(cmd.shift && rq_r))
    else $error("new word and shifted word on the write port together");

  a_cnt_update: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_inc || cmd.cnt_dec) |=> (fill_r != $past(fill_r)))
    else $error("fill count did not move");

endmodule

>>> src/ple_ctrl.sv
// Controller of the positional list engine: sequences check, shift, scan and
// result hand-off, and owns the handshake flags. Depends on ple_pkg.
module ple_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ple_pkg::sts_t sts,
  output ple_pkg::cmd_t cmd
);

  ple_pkg::state_t state_r;
  ple_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ple_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ple_pkg::S_IDLE: begin
        // take no request while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = ple_pkg::S_CHECK;
        end
      end
      ple_pkg::S_CHECK: begin
        cmd.setup = 1'b1;
        if (sts.early) state_nxt = ple_pkg::S_DONE;
        else if (sts.op == ple_pkg::OP_INS)
          state_nxt = sts.direct ? ple_pkg::S_WRITE : ple_pkg::S_UP;
        else if (sts.op == ple_pkg::OP_REM) state_nxt = ple_pkg::S_DOWN;
        else state_nxt = ple_pkg::S_SCAN;
      end
      ple_pkg::S_UP, ple_pkg::S_DOWN: begin
        cmd.rd    = 1'b1;
        cmd.shift = 1'b1;
        if (sts.last) state_nxt = ple_pkg::S_DRAIN;
      end
      ple_pkg::S_DRAIN: begin
        // retire the last word in flight
        cmd.shift = 1'b1;
        if (sts.op == ple_pkg::OP_INS) begin
          state_nxt = ple_pkg::S_WRITE;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = ple_pkg::S_DONE;
        end
      end
      ple_pkg::S_WRITE: begin
        cmd.wr_val  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = ple_pkg::S_DONE;
      end
      ple_pkg::S_SCAN: begin
        cmd.rd   = 1'b1;
        cmd.scan = 1'b1;
        if (sts.match) state_nxt = ple_pkg::S_DONE;
        else if (sts.last) state_nxt = ple_pkg::S_SCAN_LAST;
      end
      ple_pkg::S_SCAN_LAST: begin
        cmd.scan  = 1'b1;
        state_nxt = ple_pkg::S_DONE;
      end
      ple_pkg::S_DONE: begin
        // hold until the output register is free
        if (slot_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ple_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ple_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/positional_list_engine.sv
// Positional list engine: one request in, one result out per request.
// Insert and remove shift entries and search scans them, walking the entry memory one
// word a cycle with a single write port; an append and a rejected or unknown request
// skip the walk. A new request is accepted only from idle, in the cycle after the
// result is registered, which waits for a held result to be taken.
// Reset clears the fill count and handshake state; entries are not cleared.
module positional_list_engine (
  input logic      clk,
  input logic      rst_n,
  ple_req_if.sink  in_req,
  ple_rsp_if.source out_rsp
);

  ple_pkg::cmd_t cmd;
  ple_pkg::sts_t sts;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ple_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .req_func   (in_req.func),
    .req_value  (in_req.value),
    .req_pos    (in_req.position),
    .rsp_status (out_rsp.status),
    .rsp_data   (out_rsp.data_out),
    .rsp_found  (out_rsp.found_index),
    .rsp_count  (out_rsp.count)
  );

endmodule
